>>> hdl/ils_pkg.sv
// Shared constants for the indexed integer list store.
// Field widths, request codes and status codes; no dependencies.
package ils_pkg;

  localparam int CAPACITY_DEF = 16;

  localparam int DATA_W    = 32;
  localparam int REQ_W     = 3;
  localparam int POS_IN_W  = 5;
  localparam int POS_OUT_W = 4;
  localparam int CNT_OUT_W = 5;
  localparam int STAT_W    = 2;

  // Request codes
  localparam logic [REQ_W-1:0] REQ_INSERT     = 3'd0;
  localparam logic [REQ_W-1:0] REQ_READ       = 3'd1;
  localparam logic [REQ_W-1:0] REQ_REMOVE     = 3'd2;
  localparam logic [REQ_W-1:0] REQ_FIND_FIRST = 3'd3;
  localparam logic [REQ_W-1:0] REQ_FIND_LAST  = 3'd4;
  localparam logic [REQ_W-1:0] REQ_MAX_POS    = 3'd5;

  // Status codes
  localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STAT_RANGE = 2'd1;
  localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;

endpackage

>>> hdl/ils_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ils_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hdl/ils_cmp.sv
// Shared compare unit of the list store: equality and signed greater-than.
// Depends on ils_pkg.
module ils_cmp (
  input  logic signed [ils_pkg::DATA_W-1:0] a,
  input  logic signed [ils_pkg::DATA_W-1:0] b,
  output logic                              eq,
  output logic                              gt
);
  import ils_pkg::*;

  assign eq = (a == b);
  assign gt = (a > b);

endmodule

>>> hdl/indexed_integer_list_store.sv
// Top level of the indexed integer list store: sequencer, entry RAM, compare unit.
// Depends on ils_pkg, ils_ram and ils_cmp.
//
//   channel   | handshake             | payload
//   ----------+-----------------------+------------------------------------------
//   request   | start / busy          | req_type, item_value, position_in
//   result    | done (one-cycle pulse)| status, value_out, position_out, found,
//             |                       | entry_count, is_empty
//
// A request transfer happens on a rising edge with start high and busy low.
// Reads, removes, searches and inserts below the tail walk the stored entries through
// one RAM read port, one entry per cycle, with no stall during the walk.
// Busy stays high from the transfer through done, then drops before the next transfer.
// Synchronous reset empties the store; entries are never cleared.
// The result is held for one cycle under done; the receiver cannot stall it.
module indexed_integer_list_store #(
  parameter int CAPACITY = ils_pkg::CAPACITY_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic [ils_pkg::REQ_W-1:0]           req_type,
  input  logic signed [ils_pkg::DATA_W-1:0]   item_value,
  input  logic [ils_pkg::POS_IN_W-1:0]        position_in,
  output logic                                done,
  output logic [ils_pkg::STAT_W-1:0]          status,
  output logic signed [ils_pkg::DATA_W-1:0]   value_out,
  output logic [ils_pkg::POS_OUT_W-1:0]       position_out,
  output logic                                found,
  output logic [ils_pkg::CNT_OUT_W-1:0]       entry_count,
  output logic                                is_empty
);
  import ils_pkg::*;

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);
  // compare width covering both the position field and the count
  localparam int CW    = (CNT_W > POS_IN_W) ? CNT_W : POS_IN_W;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_CHECK = 6'b000010,
    S_SCAN  = 6'b000100,
    S_LAST  = 6'b001000,
    S_PUT   = 6'b010000,
    S_DONE  = 6'b100000
  } state_t;

  state_t state, state_next;

  // Control state
  logic [CNT_W-1:0] occ;
  logic             dv;        // RAM read data valid this cycle

  // Request and working registers
  logic [REQ_W-1:0]         kind;
  logic signed [DATA_W-1:0] val;
  logic [POS_IN_W-1:0]      pos;
  logic [STAT_W-1:0]        res_status;
  logic signed [DATA_W-1:0] vout;
  logic [IDX_W-1:0]         pout;
  logic                     hit;
  logic signed [DATA_W-1:0] best;
  logic [IDX_W-1:0]         rd_ptr;
  logic [IDX_W-1:0]         rd_end;
  logic                     rd_down;
  logic [IDX_W-1:0]         d_idx;     // index of the word on the RAM output

  // Check decisions
  logic [STAT_W-1:0] chk_status;
  logic              chk_go;
  logic              chk_put;
  logic [IDX_W-1:0]  chk_start;
  logic [IDX_W-1:0]  chk_end;
  logic              chk_down;

  logic [CW-1:0]     pos_w;
  logic [CW-1:0]     occ_w;
  logic [IDX_W-1:0]  pos_idx;
  logic [IDX_W-1:0]  occ_last;
  logic              scan_end;

  // RAM and compare unit
  logic              ram_we;
  logic [IDX_W-1:0]  ram_waddr;
  logic [DATA_W-1:0] ram_wdata;
  logic [DATA_W-1:0] ram_rdata;
  logic signed [DATA_W-1:0] cmp_b;
  logic              cmp_eq;
  logic              cmp_gt;

  assign pos_w    = CW'(pos);
  assign occ_w    = CW'(occ);
  assign pos_idx  = IDX_W'(pos);
  assign occ_last = IDX_W'(occ - 1'b1);
  assign scan_end = (rd_ptr == rd_end);

  // Decide the walk for the latched request.
  always_comb begin
    chk_status = STAT_OK;
    chk_go     = 1'b0;
    chk_put    = 1'b0;
    chk_start  = '0;
    chk_end    = '0;
    chk_down   = 1'b0;
    case (kind)
      REQ_INSERT: begin
        if (pos_w > occ_w) begin
          chk_status = STAT_RANGE;
        end else if (occ == CNT_W'(CAPACITY)) begin
          chk_status = STAT_FULL;
        end else if (pos_w == occ_w) begin
          chk_put = 1'b1;
        end else begin
          // move entries pos..occ-1 up one place, top first
          chk_go    = 1'b1;
          chk_start = occ_last;
          chk_end   = pos_idx;
          chk_down  = 1'b1;
        end
      end
      REQ_READ: begin
        if (pos_w >= occ_w) begin
          chk_status = STAT_RANGE;
        end else begin
          chk_go    = 1'b1;
          chk_start = pos_idx;
          chk_end   = pos_idx;
        end
      end
      REQ_REMOVE: begin
        if (pos_w >= occ_w) begin
          chk_status = STAT_RANGE;
        end else begin
          chk_go    = 1'b1;
          chk_start = pos_idx;
          chk_end   = occ_last;
        end
      end
      REQ_FIND_FIRST, REQ_FIND_LAST, REQ_MAX_POS: begin
        if (occ != '0) begin
          chk_go    = 1'b1;
          chk_start = '0;
          chk_end   = occ_last;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:  if (start) state_next = S_CHECK;
      S_CHECK: begin
        if (chk_go) begin
          state_next = S_SCAN;
        end else if (chk_put) begin
          state_next = S_PUT;
        end else begin
          state_next = S_DONE;
        end
      end
      S_SCAN:  if (scan_end) state_next = S_LAST;
      S_LAST:  state_next = (kind == REQ_INSERT) ? S_PUT : S_DONE;
      S_PUT:   state_next = S_DONE;
      S_DONE:  state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // RAM write: shift moves while data streams out, then the inserted value.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = ram_rdata;
    if (state == S_PUT) begin
      ram_we    = 1'b1;
      ram_waddr = pos_idx;
      ram_wdata = val;
    end else if (dv && kind == REQ_INSERT) begin
      ram_we    = 1'b1;
      ram_waddr = IDX_W'(d_idx + 1'b1);
    end else if (dv && kind == REQ_REMOVE && d_idx != pos_idx) begin
      ram_we    = 1'b1;
      ram_waddr = IDX_W'(d_idx - 1'b1);
    end
  end

  assign cmp_b = (kind == REQ_MAX_POS) ? best : val;

  ils_ram #(
    .WIDTH (DATA_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (rd_ptr),
    .rdata (ram_rdata)
  );

  ils_cmp u_cmp (
    .a  (ram_rdata),
    .b  (cmp_b),
    .eq (cmp_eq),
    .gt (cmp_gt)
  );

  // Control state: sequencer, count, read-data valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      occ   <= '0;
      dv    <= 1'b0;
    end else begin
      state <= state_next;
      dv    <= (state == S_SCAN);
      if (state == S_LAST && kind == REQ_REMOVE) begin
        occ <= CNT_W'(occ - 1'b1);
      end else if (state == S_PUT) begin
        occ <= CNT_W'(occ + 1'b1);
      end
    end
  end

  // Request, walk pointer and result registers.
  always_ff @(posedge clk) begin
    if (state == S_IDLE && start) begin
      // latch the transfer and clear the result
      kind       <= req_type;
      val        <= item_value;
      pos        <= position_in;
      res_status <= STAT_OK;
      vout       <= '0;
      pout       <= '0;
      hit        <= 1'b0;
    end
    if (state == S_CHECK) begin
      res_status <= chk_status;
      rd_ptr     <= chk_start;
      rd_end     <= chk_end;
      rd_down    <= chk_down;
    end
    if (state == S_SCAN) begin
      d_idx <= rd_ptr;
      if (!scan_end) begin
        // advance the read pointer toward the end of the walk
        rd_ptr <= rd_down ? IDX_W'(rd_ptr - 1'b1) : IDX_W'(rd_ptr + 1'b1);
      end
    end
    if (dv) begin
      case (kind)
        REQ_READ: vout <= ram_rdata;
        REQ_REMOVE: begin
          if (d_idx == pos_idx) vout <= ram_rdata;
        end
        REQ_FIND_FIRST: begin
          if (cmp_eq && !hit) begin
            hit  <= 1'b1;
            pout <= d_idx;
          end
        end
        REQ_FIND_LAST: begin
          if (cmp_eq) begin
            hit  <= 1'b1;
            pout <= d_idx;
          end
        end
        REQ_MAX_POS: begin
          // strict compare keeps the first position of the maximum
          if (!hit || cmp_gt) begin
            hit  <= 1'b1;
            best <= ram_rdata;
            pout <= d_idx;
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign busy         = (state != S_IDLE);
  assign done         = (state == S_DONE);
  assign status       = res_status;
  assign value_out    = vout;
  assign position_out = POS_OUT_W'(pout);
  assign found        = hit;
  assign entry_count  = CNT_OUT_W'(occ);
  assign is_empty     = (occ == '0);

  // The result strobe lasts one cycle.
  a_done_pulse: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("done held longer than one cycle");

  // The count never passes the capacity.
  a_occ_bound: assert property (@(posedge clk) disable iff (rst)
    occ <= CNT_W'(CAPACITY))
    else $error("occupancy above capacity");

  // A full status only when the store is full.
  a_full_status: assert property (@(posedge clk) disable iff (rst)
    (done && res_status == STAT_FULL) |-> (occ == CNT_W'(CAPACITY)))
    else $error("full status with room left");

  // A rejected request reports no match.
  a_err_nohit: assert property (@(posedge clk) disable iff (rst)
    (done && res_status != STAT_OK) |-> !hit)
    else $error("found set on an error result");

  // The RAM is written only inside a request.
  a_we_busy: assert property (@(posedge clk) disable iff (rst) ram_we |-> busy)
    else $error("RAM write while idle");

endmodule

>>> verif/indexed_integer_list_store_test.sv
// Self-checking testbench for indexed_integer_list_store: a directed table followed by
// random fill/drain/mixed episodes, each result checked against its table row or an in-bench list model.
// Depends on ils_pkg and the indexed_integer_list_store RTL.
`timescale 1ns / 100ps

module indexed_integer_list_store_test;
  import ils_pkg::*;

  localparam int LIST_DEPTH = CAPACITY_DEF;
  localparam int RANDOM_ITEMS = 1700;
  // Tail wait after the last result, longer than the longest request.
  localparam int DRAIN_CYCLES = LIST_DEPTH + 8;

  // Request codes the block does not decode; they must leave the store alone.
  localparam logic [REQ_W-1:0] REQ_SPARE_LO = 3'd6;
  localparam logic [REQ_W-1:0] REQ_SPARE_HI = 3'd7;

  localparam logic signed [DATA_W-1:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [DATA_W-1:0] VAL_MAX = 32'sh7fff_ffff;

  // Episode flavors for the random part.
  localparam int EP_FILL  = 0;
  localparam int EP_DRAIN = 1;
  localparam int EP_MIXED = 2;

  typedef struct packed {
    logic [STAT_W-1:0]        status;
    logic signed [DATA_W-1:0] value;
    logic [POS_OUT_W-1:0]     position;
    logic                     found;
    logic [CNT_OUT_W-1:0]     count;
    logic                     empty;
  } list_result_t;

  typedef struct packed {
    logic [REQ_W-1:0]         op;
    logic signed [DATA_W-1:0] value;
    logic [POS_IN_W-1:0]      pos;
    logic                     typed;
    list_result_t             want;
  } stim_row_t;

  localparam int DIRECTED_ROWS = 25;

  // Directed table. Rows with typed set carry an expectation that can be read off
  // at a glance; the rest are checked against the list model.
  stim_row_t directed_rows [0:DIRECTED_ROWS-1] = '{
    // empty store: every read/remove is out of range, searches miss
    '{REQ_READ,       32'sd0,    5'd0,  1'b1, '{STAT_RANGE, 32'sd0, 4'd0, 1'b0, 5'd0, 1'b1}},
    '{REQ_REMOVE,     32'sd0,    5'd0,  1'b1, '{STAT_RANGE, 32'sd0, 4'd0, 1'b0, 5'd0, 1'b1}},
    '{REQ_FIND_FIRST, 32'sd0,    5'd0,  1'b1, '{STAT_OK,    32'sd0, 4'd0, 1'b0, 5'd0, 1'b1}},
    '{REQ_FIND_LAST,  -32'sd1,   5'd0,  1'b1, '{STAT_OK,    32'sd0, 4'd0, 1'b0, 5'd0, 1'b1}},
    '{REQ_MAX_POS,    32'sd0,    5'd0,  1'b1, '{STAT_OK,    32'sd0, 4'd0, 1'b0, 5'd0, 1'b1}},
    '{REQ_INSERT,     32'sd5,    5'd1,  1'b1, '{STAT_RANGE, 32'sd0, 4'd0, 1'b0, 5'd0, 1'b1}},
    // extremes of the value range
    '{REQ_INSERT,     VAL_MIN,   5'd0,  1'b1, '{STAT_OK,    32'sd0, 4'd0, 1'b0, 5'd1, 1'b0}},
    '{REQ_INSERT,     VAL_MAX,   5'd1,  1'b1, '{STAT_OK,    32'sd0, 4'd0, 1'b0, 5'd2, 1'b0}},
    '{REQ_READ,       32'sd0,    5'd1,  1'b1, '{STAT_OK,    VAL_MAX, 4'd0, 1'b0, 5'd2, 1'b0}},
    '{REQ_READ,       32'sd0,    5'd0,  1'b1, '{STAT_OK,    VAL_MIN, 4'd0, 1'b0, 5'd2, 1'b0}},
    '{REQ_MAX_POS,    32'sd0,    5'd0,  1'b1, '{STAT_OK,    32'sd0, 4'd1, 1'b1, 5'd2, 1'b0}},
    '{REQ_FIND_FIRST, VAL_MIN,   5'd0,  1'b1, '{STAT_OK,    32'sd0, 4'd0, 1'b1, 5'd2, 1'b0}},
    // duplicates: insert in the middle and at the tail, then search both ways
    '{REQ_INSERT,     -32'sd1,   5'd1,  1'b0, '0},
    '{REQ_INSERT,     -32'sd1,   5'd3,  1'b0, '0},
    '{REQ_FIND_FIRST, -32'sd1,   5'd0,  1'b0, '0},
    '{REQ_FIND_LAST,  -32'sd1,   5'd0,  1'b0, '0},
    '{REQ_FIND_LAST,  32'sd12345, 5'd0, 1'b0, '0},
    // undecoded request codes
    '{REQ_SPARE_LO,   VAL_MAX,   5'd31, 1'b1, '{STAT_OK,    32'sd0, 4'd0, 1'b0, 5'd4, 1'b0}},
    '{REQ_SPARE_HI,   VAL_MIN,   5'd0,  1'b1, '{STAT_OK,    32'sd0, 4'd0, 1'b0, 5'd4, 1'b0}},
    // positions just past the end and at the top of the field
    '{REQ_REMOVE,     32'sd0,    5'd31, 1'b1, '{STAT_RANGE, 32'sd0, 4'd0, 1'b0, 5'd4, 1'b0}},
    '{REQ_READ,       32'sd0,    5'd4,  1'b1, '{STAT_RANGE, 32'sd0, 4'd0, 1'b0, 5'd4, 1'b0}},
    '{REQ_INSERT,     32'sd9,    5'd5,  1'b1, '{STAT_RANGE, 32'sd0, 4'd0, 1'b0, 5'd4, 1'b0}},
    // remove at head and tail
    '{REQ_REMOVE,     32'sd0,    5'd0,  1'b0, '0},
    '{REQ_REMOVE,     32'sd0,    5'd2,  1'b0, '0},
    '{REQ_MAX_POS,    32'sd0,    5'd0,  1'b0, '0}
  };

  logic                     clk;
  logic                     rst;
  logic                     start;
  logic                     busy;
  logic [REQ_W-1:0]         req_type;
  logic signed [DATA_W-1:0] item_value;
  logic [POS_IN_W-1:0]      position_in;
  logic                     done;
  logic [STAT_W-1:0]        status;
  logic signed [DATA_W-1:0] value_out;
  logic [POS_OUT_W-1:0]     position_out;
  logic                     found;
  logic [CNT_OUT_W-1:0]     entry_count;
  logic                     is_empty;

  // List model state: mirrors the store as seen through accepted requests.
  logic signed [DATA_W-1:0] model_entries [0:LIST_DEPTH-1];
  int                       model_count;

  // Results owed by the block, oldest first.
  list_result_t pending_results [$];
  int           fail_count;
  bit           idle_enabled;

  indexed_integer_list_store dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .req_type     (req_type),
    .item_value   (item_value),
    .position_in  (position_in),
    .done         (done),
    .status       (status),
    .value_out    (value_out),
    .position_out (position_out),
    .found        (found),
    .entry_count  (entry_count),
    .is_empty     (is_empty)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  // Apply one accepted request to the list model and return the result it owes.
  function automatic list_result_t predict_list_op(input logic [REQ_W-1:0] op,
                                                   input logic signed [DATA_W-1:0] val,
                                                   input logic [POS_IN_W-1:0] pos);
    list_result_t             res;
    logic signed [DATA_W-1:0] best;
    int                       p;
    res = '0;
    p = pos;
    case (op)
      REQ_INSERT: begin
        // range check wins over the full check
        if (p > model_count) begin
          res.status = STAT_RANGE;
        end else if (model_count >= LIST_DEPTH) begin
          res.status = STAT_FULL;
        end else begin
          for (int i = model_count; i > p; i--) model_entries[i] = model_entries[i-1];
          model_entries[p] = val;
          model_count++;
        end
      end
      REQ_READ: begin
        if (p >= model_count) res.status = STAT_RANGE;
        else res.value = model_entries[p];
      end
      REQ_REMOVE: begin
        if (p >= model_count) begin
          res.status = STAT_RANGE;
        end else begin
          res.value = model_entries[p];
          for (int i = p; i + 1 < model_count; i++) model_entries[i] = model_entries[i+1];
          model_count--;
        end
      end
      REQ_FIND_FIRST: begin
        for (int i = model_count - 1; i >= 0; i--) begin
          if (model_entries[i] == val) begin
            res.found = 1'b1;
            res.position = POS_OUT_W'(i);
          end
        end
      end
      REQ_FIND_LAST: begin
        for (int i = 0; i < model_count; i++) begin
          if (model_entries[i] == val) begin
            res.found = 1'b1;
            res.position = POS_OUT_W'(i);
          end
        end
      end
      REQ_MAX_POS: begin
        // signed compare; strict greater keeps the first of equal maxima
        if (model_count > 0) begin
          best = model_entries[0];
          res.found = 1'b1;
          for (int i = 1; i < model_count; i++) begin
            if (model_entries[i] > best) begin
              best = model_entries[i];
              res.position = POS_OUT_W'(i);
            end
          end
        end
      end
      default: ;
    endcase
    res.count = CNT_OUT_W'(model_count);
    res.empty = (model_count == 0);
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [DATA_W-1:0] got,
                                 input logic [DATA_W-1:0] want);
    $display("%0t: %s got %h want %h", $time, what, got, want);
    fail_count++;
  endtask

  // Check every done pulse against the oldest owed result. Sample at the rising
  // edge, before the block's registers move.
  always @(posedge clk) begin
    list_result_t want;
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with none owed, status", DATA_W'(status), '0);
      end else begin
        want = pending_results.pop_front();
        if (status !== want.status)
          report_mismatch("status", DATA_W'(status), DATA_W'(want.status));
        if (value_out !== want.value) report_mismatch("value_out", value_out, want.value);
        if (position_out !== want.position)
          report_mismatch("position_out", DATA_W'(position_out), DATA_W'(want.position));
        if (found !== want.found)
          report_mismatch("found", DATA_W'(found), DATA_W'(want.found));
        if (entry_count !== want.count)
          report_mismatch("entry_count", DATA_W'(entry_count), DATA_W'(want.count));
        if (is_empty !== want.empty)
          report_mismatch("is_empty", DATA_W'(is_empty), DATA_W'(want.empty));
      end
    end
  end

  // Idle gap: mostly none, sometimes short, rarely a long pause.
  function automatic int pick_idle_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!idle_enabled || r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Present one request from a falling edge, hold it until the transfer, record the
  // owed result, then idle. Start stays high across back-to-back requests.
  task automatic send_request(input logic [REQ_W-1:0] op, input logic signed [DATA_W-1:0] val,
                              input logic [POS_IN_W-1:0] pos, input logic typed,
                              input list_result_t want);
    list_result_t predicted;
    int           gap;
    start = 1'b1;
    req_type = op;
    item_value = val;
    position_in = pos;
    forever begin
      @(posedge clk);
      if (!busy) break;
    end
    predicted = predict_list_op(op, val, pos);
    pending_results.push_back(typed ? want : predicted);
    @(negedge clk);
    gap = pick_idle_gap();
    if (gap > 0) begin
      start = 1'b0;
      // drive junk while start is low; the block must ignore it
      repeat (gap) begin
        req_type = REQ_W'($urandom_range(0, 7));
        item_value = $urandom;
        position_in = POS_IN_W'($urandom_range(0, 31));
        @(negedge clk);
      end
    end
  endtask

  function automatic logic [REQ_W-1:0] pick_op(input int flavor);
    int r;
    int ins_w;
    int rd_w;
    int rm_w;
    r = $urandom_range(0, 99);
    case (flavor)
      EP_FILL:  begin ins_w = 60; rd_w = 10; rm_w = 5;  end
      EP_DRAIN: begin ins_w = 15; rd_w = 10; rm_w = 55; end
      default:  begin ins_w = 30; rd_w = 20; rm_w = 20; end
    endcase
    if (r < ins_w) return REQ_INSERT;
    if (r < ins_w + rd_w) return REQ_READ;
    if (r < ins_w + rd_w + rm_w) return REQ_REMOVE;
    if (r < 96) return REQ_W'(REQ_FIND_FIRST + $urandom_range(0, 2));
    return $urandom_range(0, 1) ? REQ_SPARE_LO : REQ_SPARE_HI;
  endfunction

  // Values: often something already stored so searches hit, often a small pool so
  // duplicates pile up, otherwise anything.
  function automatic logic signed [DATA_W-1:0] pick_value();
    int r;
    r = $urandom_range(0, 99);
    if (r < 30 && model_count > 0) return model_entries[$urandom_range(0, model_count - 1)];
    if (r < 60) begin
      case ($urandom_range(0, 4))
        0: return VAL_MIN;
        1: return VAL_MAX;
        2: return -32'sd1;
        3: return 32'sd0;
        default: return 32'sd7;
      endcase
    end
    return $urandom;
  endfunction

  function automatic logic [POS_IN_W-1:0] pick_position(input logic [REQ_W-1:0] op);
    if ($urandom_range(0, 99) < 12) return POS_IN_W'($urandom_range(0, 31));
    if (op == REQ_INSERT) return POS_IN_W'($urandom_range(0, model_count));
    if (model_count == 0) return 5'd0;
    return POS_IN_W'($urandom_range(0, model_count - 1));
  endfunction

  initial begin
    $timeformat(-9, 1, " ns", 10);
  end

  // Stimulus: reset, directed table, random episodes, drain, verdict.
  initial begin
    logic [REQ_W-1:0] op;
    int               issued;
    int               flavor;
    int               ep_len;
    rst = 1'b1;
    start = 1'b0;
    req_type = REQ_INSERT;
    item_value = '0;
    position_in = '0;
    fail_count = 0;
    model_count = 0;
    idle_enabled = 1'b1;
    for (int i = 0; i < LIST_DEPTH; i++) model_entries[i] = '0;

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    for (int i = 0; i < DIRECTED_ROWS; i++) begin
      send_request(directed_rows[i].op, directed_rows[i].value, directed_rows[i].pos,
                   directed_rows[i].typed, directed_rows[i].want);
    end

    // Random episodes; each leans toward filling, draining or neither, and some
    // run with no idle cycles at all.
    issued = 0;
    while (issued < RANDOM_ITEMS) begin
      flavor = $urandom_range(EP_FILL, EP_MIXED);
      ep_len = $urandom_range(10, 60);
      idle_enabled = ($urandom_range(0, 3) != 0);
      repeat (ep_len) begin
        op = pick_op(flavor);
        send_request(op, pick_value(), pick_position(op), 1'b0, '0);
        issued++;
      end
    end
    idle_enabled = 1'b1;
    start = 1'b0;

    // Hold until every owed result is in, then watch for strays.
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0) begin
      $display("indexed_integer_list_store: match");
    end else begin
      $display("indexed_integer_list_store: mismatch");
    end
    $finish;
  end

  // Drop the run if it hangs; the slowest correct run is well under 1 ms.
  initial begin
    #5_000_000;
    $display("indexed_integer_list_store: mismatch");
    $finish;
  end

endmodule
